FILE: sv/plesr_pkg.sv
// Shared types for the polyline equal-spacing resampler.
// Holds the controller states, divider operation codes and the command/status structs.
// No dependencies.
package plesr_pkg;

    localparam int SPW  = 23;   // sample spacing width
    localparam int OFFW = 24;   // carried offset width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_PLAN,
        ST_DCOUNT,
        ST_DXF,
        ST_DXS,
        ST_DYF,
        ST_DYS,
        ST_EMIT,
        ST_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        DOP_COUNT,
        DOP_XFIRST,
        DOP_XSTEP,
        DOP_YFIRST,
        DOP_YSTEP
    } t_div_op;

    typedef struct packed {
        logic    in_ready;
        logic    accept;
        logic    square;
        logic    sum;
        logic    root_step;
        logic    plan;
        logic    div_start;
        t_div_op div_op;
        logic    div_cap;
        t_div_op cap_op;
        logic    emit;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic begin_line;
        logic root_last;
        logic no_pts;
        logic div_done;
        logic last;
        logic out_free;
    } t_status;

endpackage

FILE: sv/plesr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; used by the resampler datapath.
module plesr_div #(
    parameter int NUMW = 47,
    parameter int DENW = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [NUMW-1:0] i_num,
    input  logic [DENW-1:0] i_den,
    output logic            o_done,
    output logic [NUMW-1:0] o_quo,
    output logic [DENW-1:0] o_rem
);
    localparam int CW = $clog2(NUMW);

    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [CW-1:0]   r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DENW:0]   shifted;
    logic [DENW:0]   diff;
    logic            ge;

    always_comb begin
        shifted = {r_rem, r_num[NUMW-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUMW - 1);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // The quotient bits shift into the numerator register.
                r_rem <= ge ? diff[DENW-1:0] : shifted[DENW-1:0];
                r_num <= {r_num[NUMW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;
endmodule

FILE: sv/plesr_ctrl.sv
// Controller state machine of the resampler.
// Depends on plesr_pkg for states, divider codes and command/status structs.
module plesr_ctrl
    import plesr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state;
    t_state n_state;

    function automatic logic is_div(t_state s);
        return (s == ST_DCOUNT) || (s == ST_DXF) || (s == ST_DXS) ||
               (s == ST_DYF) || (s == ST_DYS);
    endfunction

    function automatic t_div_op op_of(t_state s);
        t_div_op op;
        case (s)
            ST_DXF:  op = DOP_XFIRST;
            ST_DXS:  op = DOP_XSTEP;
            ST_DYF:  op = DOP_YFIRST;
            ST_DYS:  op = DOP_YSTEP;
            default: op = DOP_COUNT;
        endcase
        return op;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_status.in_valid && !i_status.begin_line) n_state = ST_SQUARE;
            end
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROOT;
            ST_ROOT: begin
                if (i_status.root_last) n_state = ST_PLAN;
            end
            ST_PLAN:   n_state = i_status.no_pts ? ST_COMMIT : ST_DCOUNT;
            ST_DCOUNT: begin
                if (i_status.div_done) n_state = ST_DXF;
            end
            ST_DXF: begin
                if (i_status.div_done) n_state = ST_DXS;
            end
            ST_DXS: begin
                if (i_status.div_done) n_state = ST_DYF;
            end
            ST_DYF: begin
                if (i_status.div_done) n_state = ST_DYS;
            end
            ST_DYS: begin
                if (i_status.div_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.last) n_state = ST_COMMIT;
            end
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.in_ready  = (r_state == ST_IDLE);
        o_cmd.accept    = (r_state == ST_IDLE) && i_status.in_valid;
        o_cmd.square    = (r_state == ST_SQUARE);
        o_cmd.sum       = (r_state == ST_SUM);
        o_cmd.root_step = (r_state == ST_ROOT);
        o_cmd.plan      = (r_state == ST_PLAN);
        o_cmd.div_start = is_div(n_state) && (n_state != r_state);
        o_cmd.div_op    = op_of(n_state);
        o_cmd.div_cap   = is_div(r_state) && i_status.div_done;
        o_cmd.cap_op    = op_of(r_state);
        o_cmd.emit      = (r_state == ST_EMIT) && i_status.out_free;
        o_cmd.commit    = (r_state == ST_COMMIT);
    end
endmodule

FILE: sv/plesr_dp.sv
// Datapath of the resampler: vertex state, square root, divider operands,
// per-point interpolation accumulators and the output register.
// Depends on plesr_pkg and plesr_div.
module plesr_dp
    import plesr_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_SAMPLES = 64,
    parameter int TDW         = 48
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_status        o_status,
    input  logic           i_in_valid,
    input  logic [TDW-1:0] i_in_data,
    input  logic           i_in_start,
    input  logic           i_cfg_we,
    input  logic [SPW-1:0] i_cfg_wdata,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [TDW-1:0] o_out_data,
    output logic           o_out_last,
    output logic           o_out_trunc
);
    localparam int W    = COORD_WIDTH;
    localparam int LW   = W + 1;
    localparam int SQW  = 2 * W + 2;
    localparam int RW   = W + 4;
    localparam int RCW  = $clog2(W + 1);
    localparam int NUMW = W + SPW;
    localparam int DENW = (LW > SPW) ? LW : SPW;
    localparam int XW   = ((LW > OFFW) ? LW : OFFW) + 1;
    localparam int KW   = $clog2(MAX_SAMPLES + 1);

    // Vertex and phase state
    logic [SPW-1:0]  r_sp;
    logic [W-1:0]    r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic [OFFW-1:0] r_off, r_newoff;
    logic            r_have;
    // Segment geometry
    logic [W-1:0]    r_ax, r_ay;
    logic            r_negx, r_negy;
    logic [2*W-1:0]  r_sqx, r_sqy;
    logic [SQW-1:0]  r_sq;
    logic [LW-1:0]   r_root;
    logic [RW-1:0]   r_rrem;
    logic [RCW-1:0]  r_rcnt;
    // Point walk
    logic [KW-1:0]   r_k, r_m;
    logic            r_trunc;
    logic [LW-1:0]   r_qx, r_rx, r_rsx, r_qy, r_ry, r_rsy;
    logic [SPW-1:0]  r_qsx, r_qsy;
    // Output register
    logic            r_ovalid, r_olast, r_otrunc;
    logic [W-1:0]    r_ox, r_oy;

    logic [W-1:0]    in_x, in_y;
    logic [W:0]      dx, dy;
    logic [RW-1:0]   rt_tmp, rt_trial;
    logic [SPW-1:0]  c_spe, c_offe, c_first;
    logic [XW-1:0]   len_x, sum_x, alt_x, cnt_x;
    logic            c_fewer;
    logic [W-1:0]    mul_a;
    logic [SPW-1:0]  mul_b;
    logic [NUMW-1:0] div_num, div_quo;
    logic [DENW-1:0] div_den, div_rem;
    logic            div_done;
    logic [LW-1:0]   stp_x, stp_y;
    logic [LW:0]     adv_x, adv_y;

    plesr_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_comb begin
        in_x     = i_in_data[W-1:0];
        in_y     = i_in_data[2*W-1:W];
        dx       = {in_x[W-1], in_x} - {r_prev_x[W-1], r_prev_x};
        dy       = {in_y[W-1], in_y} - {r_prev_y[W-1], r_prev_y};
        rt_tmp   = {r_rrem[RW-3:0], r_sq[SQW-1:SQW-2]};
        rt_trial = RW'({r_root, 2'b01});

        c_spe    = (r_sp == '0) ? SPW'(1) : r_sp;
        c_offe   = (r_off > OFFW'(c_spe)) ? c_spe : r_off[SPW-1:0];
        c_first  = c_spe - c_offe;
        len_x    = XW'(r_root);
        sum_x    = len_x + XW'(c_offe);
        alt_x    = len_x + XW'(c_spe) - XW'(c_first);
        cnt_x    = len_x - XW'(1) - XW'(c_first);
        c_fewer  = sum_x < XW'(c_spe);

        mul_a = ((i_cmd.div_op == DOP_YFIRST) || (i_cmd.div_op == DOP_YSTEP)) ? r_ay : r_ax;
        mul_b = ((i_cmd.div_op == DOP_XSTEP) || (i_cmd.div_op == DOP_YSTEP)) ? c_spe : c_first;
        if (i_cmd.div_op == DOP_COUNT) begin
            div_num = NUMW'(cnt_x);
            div_den = DENW'(c_spe);
        end else begin
            div_num = NUMW'(mul_a) * NUMW'(mul_b);
            div_den = DENW'(r_root);
        end

        // Round half up: add one when the remainder is at least half the length.
        stp_x = r_qx + LW'(r_rx >= (r_root - r_rx));
        stp_y = r_qy + LW'(r_ry >= (r_root - r_ry));
        adv_x = {1'b0, r_rx} + {1'b0, r_rsx};
        adv_y = {1'b0, r_ry} + {1'b0, r_rsy};
    end

    always_comb begin
        o_status            = '0;
        o_status.in_valid   = i_in_valid;
        o_status.begin_line = i_in_start || !r_have;
        o_status.root_last  = (r_rcnt == '0);
        o_status.no_pts     = c_fewer || (XW'(c_first) >= len_x);
        o_status.div_done   = div_done;
        o_status.last       = (r_k == (r_m - KW'(1)));
        o_status.out_free   = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= SPW'(256);
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_off    <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_sp <= i_cfg_wdata;

            if (i_cmd.accept) begin
                r_cur_x <= in_x;
                r_cur_y <= in_y;
                r_ax    <= dx[W] ? W'(-dx) : dx[W-1:0];
                r_ay    <= dy[W] ? W'(-dy) : dy[W-1:0];
                r_negx  <= dx[W];
                r_negy  <= dy[W];
                if (i_in_start || !r_have) begin
                    r_prev_x <= in_x;
                    r_prev_y <= in_y;
                    r_off    <= '0;
                    r_have   <= 1'b1;
                end
            end

            if (i_cmd.square) begin
                r_sqx <= r_ax * r_ax;
                r_sqy <= r_ay * r_ay;
            end

            if (i_cmd.sum) begin
                r_sq   <= SQW'(r_sqx) + SQW'(r_sqy);
                r_root <= '0;
                r_rrem <= '0;
                r_rcnt <= RCW'(W);
            end

            if (i_cmd.root_step) begin
                r_sq   <= {r_sq[SQW-3:0], 2'b00};
                r_rcnt <= r_rcnt - 1'b1;
                if (rt_tmp >= rt_trial) begin
                    r_rrem <= rt_tmp - rt_trial;
                    r_root <= {r_root[LW-2:0], 1'b1};
                end else begin
                    r_rrem <= rt_tmp;
                    r_root <= {r_root[LW-2:0], 1'b0};
                end
            end

            if (i_cmd.plan) begin
                r_k      <= '0;
                r_newoff <= c_fewer ? sum_x[OFFW-1:0] : alt_x[OFFW-1:0];
            end

            if (i_cmd.div_cap) begin
                case (i_cmd.cap_op)
                    DOP_COUNT: begin
                        r_trunc  <= div_quo >= NUMW'(MAX_SAMPLES);
                        r_m      <= (div_quo >= NUMW'(MAX_SAMPLES)) ? KW'(MAX_SAMPLES)
                                                                    : KW'(div_quo) + KW'(1);
                        r_newoff <= {1'b0, div_rem[SPW-1:0]} + OFFW'(1);
                    end
                    DOP_XFIRST: begin
                        r_qx <= div_quo[LW-1:0];
                        r_rx <= div_rem[LW-1:0];
                    end
                    DOP_XSTEP: begin
                        r_qsx <= div_quo[SPW-1:0];
                        r_rsx <= div_rem[LW-1:0];
                    end
                    DOP_YFIRST: begin
                        r_qy <= div_quo[LW-1:0];
                        r_ry <= div_rem[LW-1:0];
                    end
                    DOP_YSTEP: begin
                        r_qsy <= div_quo[SPW-1:0];
                        r_rsy <= div_rem[LW-1:0];
                    end
                    default: begin
                        r_trunc <= 1'b0;
                    end
                endcase
            end

            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
                r_ox     <= r_negx ? r_prev_x - stp_x[W-1:0] : r_prev_x + stp_x[W-1:0];
                r_oy     <= r_negy ? r_prev_y - stp_y[W-1:0] : r_prev_y + stp_y[W-1:0];
                r_olast  <= o_status.last;
                r_otrunc <= o_status.last && r_trunc;
                r_k      <= r_k + 1'b1;
                // Step the quotient/remainder pairs by one spacing.
                if (adv_x >= {1'b0, r_root}) begin
                    r_rx <= LW'(adv_x - {1'b0, r_root});
                    r_qx <= r_qx + LW'(r_qsx) + LW'(1);
                end else begin
                    r_rx <= adv_x[LW-1:0];
                    r_qx <= r_qx + LW'(r_qsx);
                end
                if (adv_y >= {1'b0, r_root}) begin
                    r_ry <= LW'(adv_y - {1'b0, r_root});
                    r_qy <= r_qy + LW'(r_qsy) + LW'(1);
                end else begin
                    r_ry <= adv_y[LW-1:0];
                    r_qy <= r_qy + LW'(r_qsy);
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            if (i_cmd.commit) begin
                r_prev_x <= r_cur_x;
                r_prev_y <= r_cur_y;
                r_off    <= r_newoff;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = TDW'({r_oy, r_ox});
    assign o_out_last  = r_olast;
    assign o_out_trunc = r_otrunc;
endmodule

FILE: sv/polyline_equal_spacing_resampler.sv
// Top level of the polyline equal-spacing resampler.
// Instantiates plesr_ctrl and plesr_dp; depends on plesr_pkg.
//
//  channel   direction  ports                     payload
//  -------   ---------  ------------------------  ----------------------------------
//  s_axis    in         tvalid/tready/tdata/tuser  vertex x, y; tuser = start_polyline
//  m_axis    out        tvalid/tready/tdata/tlast  sample x, y; tlast = last_sample,
//                       /tuser                     tuser = truncated
//  cfg       in         i_cfg_we/i_cfg_wdata       sample_spacing, write only
//
// One vertex is processed at a time. A vertex that starts a polyline is only
// stored, and the controller stays idle. A segment vertex goes through the
// squares and the bit-pair square root; if it yields points, five runs of the
// shared one-bit-per-cycle divider follow, and then the point walk emits them.
// Reset is synchronous and active low; it restores the spacing to 256 and
// clears the stored vertex and offset. A stalled m_axis holds the point walk.
module polyline_equal_spacing_resampler
    import plesr_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, lowest bit first: point_x, point_y, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    // tuser: start_polyline
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata, lowest bit first: sample_x, sample_y, zero fill
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    output logic                                 m_axis_tlast,
    // tuser: truncated
    output logic                                 m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  logic [SPW-1:0]                       i_cfg_wdata
);
    localparam int TDW = ((2 * COORD_WIDTH + 7) / 8) * 8;

    t_cmd    cmd;
    t_status status;

    // The controller sequences squaring, root, the divider runs and the point walk.
    plesr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // The datapath holds all arithmetic and the output register.
    plesr_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_SAMPLES (MAX_SAMPLES),
        .TDW         (TDW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_valid  (s_axis_tvalid),
        .i_in_data   (s_axis_tdata),
        .i_in_start  (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_trunc (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;

    // No vertex is taken while points of a segment are being produced.
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !s_axis_tready)
        else $error("vertex accepted during point emission");

    // The truncation flag only ever rides on the last point of a segment.
    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("truncated set on a point that is not last");

    // After the phase is committed the block is ready for the next vertex.
    a_commit_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> s_axis_tready)
        else $error("not ready after segment commit");
endmodule

FILE: tb/polyline_equal_spacing_resampler_tb.sv
// Self-checking testbench for polyline_equal_spacing_resampler.
// Predicts every emitted sample point in SystemVerilog and checks the stream output.
// Depends on plesr_pkg and the resampler RTL.
module polyline_equal_spacing_resampler_tb
    import plesr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = 24;
    localparam int MAX_PTS   = 64;
    localparam int SETTLE    = 400;       // covers a segment with no points still in flight
    localparam int LIMIT     = 3000000;

    typedef struct {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic         last;
        logic         trunc;
    } t_sample;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [47:0]    s_axis_tdata;
    logic           s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [47:0]    m_axis_tdata;
    logic           m_axis_tlast;
    logic           m_axis_tuser;
    logic           i_cfg_we;
    logic [SPW-1:0] i_cfg_wdata;

    polyline_equal_spacing_resampler #(.COORD_WIDTH(W), .MAX_SAMPLES(MAX_PTS)) dut (.*);

    // Predictor state, kept in step with every accepted vertex transaction.
    logic [SPW-1:0]     spacing_reg;
    longint             prev_x;
    longint             prev_y;
    longint unsigned    walked;
    bit                 holding_vertex;

    t_sample pending_samples[$];
    int      error_count;
    int      cycle_count;
    bit      steady;          // when set, neither side idles

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: a correct run finishes far below this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver drops tready at random, 17 percent of the time, unless the steady stretch is on.
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 17);
    end

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        root = 0;
        rem  = 0;
        for (int i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // Point at distance d along delta of length len, rounded half away from zero.
    function automatic logic [W-1:0] point_along(longint base, longint delta,
                                                 longint unsigned d, longint unsigned len);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned q;
        longint unsigned r;
        mag  = (delta < 0) ? longint'(-delta) : longint'(delta);
        prod = mag * d;
        q    = prod / len;
        r    = prod % len;
        if (r >= len - r) begin
            q++;
        end
        return (delta < 0) ? W'(base - longint'(q)) : W'(base + longint'(q));
    endfunction

    // Works out the sample points caused by one accepted vertex and queues them.
    task automatic predict_vertex(logic [W-1:0] px, logic [W-1:0] py, logic start);
        longint          x;
        longint          y;
        longint          dx;
        longint          dy;
        longint unsigned len;
        longint unsigned sp;
        longint unsigned off;
        longint unsigned first;
        longint unsigned n;
        longint unsigned m;
        longint unsigned new_off;
        t_sample         s;
        x = longint'($signed(px));
        y = longint'($signed(py));
        if (start || !holding_vertex) begin
            prev_x         = x;
            prev_y         = y;
            walked         = 0;
            holding_vertex = 1'b1;
            return;
        end
        dx  = x - prev_x;
        dy  = y - prev_y;
        len = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
        // A zero spacing behaves as one, and a stale offset is clipped to the spacing.
        sp  = (spacing_reg == 0) ? 1 : spacing_reg;
        off = (walked > sp) ? sp : walked;
        if (len + off < sp) begin
            new_off = len + off;
        end else begin
            first = sp - off;
            n = (first < len) ? (len - 1 - first) / sp + 1 : 0;
            m = (n > MAX_PTS) ? MAX_PTS : n;
            new_off = (n == 0) ? len + sp - first : len - (first + (n - 1) * sp);
            for (longint unsigned k = 0; k < m; k++) begin
                s.x     = point_along(prev_x, dx, first + k * sp, len);
                s.y     = point_along(prev_y, dy, first + k * sp, len);
                s.last  = (k + 1 == m);
                s.trunc = (k + 1 == m) && (n > MAX_PTS);
                pending_samples.insert(pending_samples.size(), s);
            end
        end
        prev_x = x;
        prev_y = y;
        walked = new_off & 64'hFF_FFFF;
    endtask

    // Checks each output transaction against the oldest predicted sample.
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected sample x=%h y=%h", m_axis_tdata[23:0], m_axis_tdata[47:24]);
                error_count++;
            end else begin
                exp_s = pending_samples.pop_front();
                if (m_axis_tdata[23:0] !== exp_s.x) begin
                    $error("sample_x expected %h actual %h", exp_s.x, m_axis_tdata[23:0]);
                    error_count++;
                end
                if (m_axis_tdata[47:24] !== exp_s.y) begin
                    $error("sample_y expected %h actual %h", exp_s.y, m_axis_tdata[47:24]);
                    error_count++;
                end
                if (m_axis_tlast !== exp_s.last) begin
                    $error("last_sample expected %b actual %b", exp_s.last, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== exp_s.trunc) begin
                    $error("truncated expected %b actual %b", exp_s.trunc, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Sends one vertex transaction, with random idle cycles ahead of it.
    task automatic send_vertex(logic [W-1:0] px, logic [W-1:0] py, logic start);
        while (!steady && $urandom_range(99) < 17) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px};
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        predict_vertex(px, py, start);
    endtask

    // Stops sending and waits until every predicted sample has arrived and the
    // block has had time to finish a segment that yields no points.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_spacing(logic [SPW-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        spacing_reg = value;
    endtask

    function automatic logic [W-1:0] near(longint base, int span);
        return W'(base + longint'($urandom_range(2 * span)) - span);
    endfunction

    // Mostly well-formed polylines walking in random steps of up to span per axis, some
    // vertices thrown anywhere in the coordinate range.
    task automatic random_polylines(int count, int span);
        longint cx;
        longint cy;
        int     left;
        cx = 0;
        cy = 0;
        left = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 12) begin
                cx = longint'($signed(W'($urandom())));
                cy = longint'($signed(W'($urandom())));
                send_vertex(W'(cx), W'(cy), 1'($urandom_range(1)));
            end else begin
                if (left == 0) begin
                    left = $urandom_range(8, 2);
                    send_vertex(W'(cx), W'(cy), 1'b1);
                end else begin
                    cx = longint'($signed(near(cx, span)));
                    cy = longint'($signed(near(cy, span)));
                    send_vertex(W'(cx), W'(cy), 1'b0);
                    left--;
                end
            end
        end
    endtask

    // Corner cases at the reset spacing of one point every 256 units.
    task automatic test_directed();
        send_vertex(24'd0, 24'd0, 1'b0);                 // no previous vertex yet
        send_vertex(24'd1024, 24'd0, 1'b0);              // three points, offset ends at spacing
        send_vertex(24'd1024, 24'd1024, 1'b0);           // point at segment start
        send_vertex(24'd1024, 24'd1024, 1'b0);           // zero-length segment
        send_vertex(24'h80_0000, 24'h80_0000, 1'b0);     // huge, truncated
        send_vertex(24'h7F_FFFF, 24'h7F_FFFF, 1'b0);     // opposite corner
        send_vertex(24'h7F_FFFF, 24'h80_0000, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(24'd256, 24'd0, 1'b0);               // length equals spacing
        send_vertex(24'd256, -24'sd300, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(24'd768, 24'd1024, 1'b0);            // 3-4-5 diagonal
        send_vertex(24'd773, 24'd1024, 1'b0);            // short, one point at its start
        send_vertex(-24'sd500, 24'd1000, 1'b0);          // negative deltas
        send_vertex(-24'sd500, -24'sd20000, 1'b0);       // more than 64 points, truncated
        send_vertex(24'd1, 24'd1, 1'b1);
        send_vertex(24'd1, 24'd16641, 1'b0);             // exactly 64 points, not truncated
    endtask

    // Lowering the spacing mid-polyline leaves a larger offset to clip.
    task automatic test_spacing_lowered();
        write_spacing(23'd4096);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(24'd3000, 24'd0, 1'b0);
        write_spacing(23'd512);
        send_vertex(24'd3000, 24'd2000, 1'b0);
    endtask

    task automatic test_spacing_extremes();
        write_spacing(23'd1);
        random_polylines(40, 60);
        write_spacing(23'h7F_FFFF);
        random_polylines(40, 1 << 22);
        write_spacing(23'd0);
        random_polylines(30, 40);
    endtask

    task automatic test_random_spacing();
        steady = 1'b1;                       // long stretch with no idling on either side
        random_polylines(70, 1200);
        steady = 1'b0;
        drain();                             // sender waits for every result, then resumes
        random_polylines(30, 1200);
        write_spacing(SPW'($urandom_range(5000, 100)));
        random_polylines(140, 8000);
    endtask

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        spacing_reg    = 23'd256;
        prev_x         = 0;
        prev_y         = 0;
        walked         = 0;
        holding_vertex = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_spacing_lowered();
        test_spacing_extremes();
        test_random_spacing();

        drain();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
